@@ rtl/ddnc_pkg.sv @@
// Package for the date / day number converter: transfer structs, microcode
// control word, sequencer status and calendar helper functions.
// No dependencies.
package ddnc_pkg;

  localparam logic [11:0] EPOCH_YEAR  = 12'd1901;
  localparam logic [11:0] BASE_YEAR   = 12'd1601;
  localparam logic [19:0] LAST_DAY    = 20'd801707;
  localparam logic [19:0] EPOCH_OFS   = 20'd109572;
  localparam logic [2:0]  WD_BASE     = 3'd1;
  localparam logic [3:0]  MONTHS      = 4'd12;
  localparam logic [4:0]  FINAL_BLOCK = 5'd24;
  localparam logic [1:0]  FINAL_CENT  = 2'd3;
  localparam logic [1:0]  LEAP_POS    = 2'd3;
  localparam int unsigned PC_W        = 4;

  typedef struct packed {
    logic        command;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [19:0] day_number;
  } in_item_t;

  typedef struct packed {
    logic        valid_res;
    logic [19:0] out_day_number;
    logic [11:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [2:0]  weekday;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_STAGE,
    OP_MSETUP,
    OP_MONTH,
    OP_EMIT
  } op_e;

  typedef enum logic [1:0] {
    JC_NEXT,
    JC_FAIL,
    JC_LOOP,
    JC_END
  } jc_e;

  typedef enum logic [2:0] {
    TL_NONE,
    TL_CENT,
    TL_B8,
    TL_B1,
    TL_YEAR
  } tally_e;

  typedef enum logic {
    SQ_IDLE,
    SQ_RUN
  } seq_state_e;

  typedef struct packed {
    op_e             op;
    jc_e             jc;
    logic [PC_W-1:0] target;
    logic [8:0]      yr_step;
    logic [17:0]     dd_step;
    logic [2:0]      cap;
    logic [2:0]      wd_step;
    tally_e          tally;
  } cw_t;

  typedef struct packed {
    logic fail;
    logic again;
  } sts_t;

  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
    logic [4:0] len;
    begin
      case (m)
        4'd2:    len = leap ? 5'd29 : 5'd28;
        4'd4:    len = 5'd30;
        4'd6:    len = 5'd30;
        4'd9:    len = 5'd30;
        4'd11:   len = 5'd30;
        default: len = 5'd31;
      endcase
      return len;
    end
  endfunction

  function automatic logic [2:0] mod7(input logic [4:0] v);
    logic [4:0] r;
    begin
      if (v >= 5'd28) begin
        r = v - 5'd28;
      end else if (v >= 5'd21) begin
        r = v - 5'd21;
      end else if (v >= 5'd14) begin
        r = v - 5'd14;
      end else if (v >= 5'd7) begin
        r = v - 5'd7;
      end else begin
        r = v;
      end
      return r[2:0];
    end
  endfunction

  function automatic logic [2:0] add7(input logic [2:0] a, input logic [2:0] b);
    logic [3:0] s;
    begin
      s = {1'b0, a} + {1'b0, b};
      if (s >= 4'd7) begin
        s = s - 4'd7;
      end
      return s[2:0];
    end
  endfunction

endpackage

@@ rtl/ddnc_seq.sv @@
// Microcode sequencer: program ROM, step counter and conditional jumps.
// Depends on ddnc_pkg.
module ddnc_seq import ddnc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  sts_t sts_i,
  input  logic out_free_i,
  output logic busy_o,
  output logic emit_o,
  output cw_t  cw_o
);

  localparam logic [PC_W-1:0] ST_LOAD   = 4'd0;
  localparam logic [PC_W-1:0] ST_Y400   = 4'd1;
  localparam logic [PC_W-1:0] ST_Y100   = 4'd2;
  localparam logic [PC_W-1:0] ST_Y32    = 4'd3;
  localparam logic [PC_W-1:0] ST_Y4     = 4'd4;
  localparam logic [PC_W-1:0] ST_Y1     = 4'd5;
  localparam logic [PC_W-1:0] ST_MSETUP = 4'd6;
  localparam logic [PC_W-1:0] ST_MONTH  = 4'd7;
  localparam logic [PC_W-1:0] ST_EMIT   = 4'd8;

  function automatic cw_t stage(input logic [PC_W-1:0] self, input logic [8:0] yrs,
                                input logic [17:0] dds, input logic [2:0] cap,
                                input logic [2:0] wds, input tally_e tl);
    cw_t w;
    begin
      w         = '0;
      w.op      = OP_STAGE;
      w.jc      = JC_LOOP;
      w.target  = self;
      w.yr_step = yrs;
      w.dd_step = dds;
      w.cap     = cap;
      w.wd_step = wds;
      w.tally   = tl;
      return w;
    end
  endfunction

  function automatic cw_t ucode(input logic [PC_W-1:0] pc);
    cw_t w;
    begin
      w = '0;
      case (pc)
        ST_LOAD: begin
          w.op     = OP_LOAD;
          w.jc     = JC_FAIL;
          w.target = ST_EMIT;
        end
        ST_Y400: w = stage(ST_Y400, 9'd400, 18'd146097, 3'd7, 3'd0, TL_NONE);
        ST_Y100: w = stage(ST_Y100, 9'd100, 18'd36524, 3'd3, 3'd5, TL_CENT);
        ST_Y32:  w = stage(ST_Y32, 9'd32, 18'd11688, 3'd7, 3'd5, TL_B8);
        ST_Y4:   w = stage(ST_Y4, 9'd4, 18'd1461, 3'd7, 3'd5, TL_B1);
        ST_Y1:   w = stage(ST_Y1, 9'd1, 18'd365, 3'd3, 3'd1, TL_YEAR);
        ST_MSETUP: begin
          w.op     = OP_MSETUP;
          w.jc     = JC_FAIL;
          w.target = ST_EMIT;
        end
        ST_MONTH: begin
          w.op     = OP_MONTH;
          w.jc     = JC_LOOP;
          w.target = ST_MONTH;
        end
        ST_EMIT: begin
          w.op     = OP_EMIT;
          w.jc     = JC_END;
          w.target = ST_LOAD;
        end
        default: begin
          w.op     = OP_EMIT;
          w.jc     = JC_END;
          w.target = ST_LOAD;
        end
      endcase
      return w;
    end
  endfunction

  seq_state_e      state_q, state_d;
  logic [PC_W-1:0] pc_q, pc_d;
  cw_t             cw;

  assign cw   = ucode(pc_q);
  assign cw_o = cw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SQ_IDLE;
      pc_q    <= ST_LOAD;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
    end
  end

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    busy_o  = 1'b0;
    emit_o  = 1'b0;
    case (state_q)
      SQ_IDLE: begin
        if (start_i) begin
          state_d = SQ_RUN;
          pc_d    = ST_LOAD;
        end
      end
      SQ_RUN: begin
        busy_o = 1'b1;
        case (cw.jc)
          JC_FAIL: pc_d = sts_i.fail ? cw.target : pc_q + 4'd1;
          JC_LOOP: pc_d = sts_i.again ? cw.target : pc_q + 4'd1;
          JC_END: begin
            if (out_free_i) begin
              emit_o  = 1'b1;
              state_d = SQ_IDLE;
              pc_d    = cw.target;
            end
          end
          default: pc_d = pc_q + 4'd1;
        endcase
      end
      default: begin
        state_d = SQ_IDLE;
        pc_d    = ST_LOAD;
      end
    endcase
  end

endmodule

@@ rtl/ddnc_dp.sv @@
// Datapath for the converter: year decomposition by 400/100/32/4/1 years,
// month walk, weekday tally and result formatting. Depends on ddnc_pkg.
module ddnc_dp import ddnc_pkg::*; (
  input  logic      clk_i,
  input  logic      in_load_i,
  input  in_item_t  in_data_i,
  input  logic      run_i,
  input  cw_t       cw_i,
  output sts_t      sts_o,
  output out_item_t res_o
);

  logic        cmd_q;
  logic [11:0] yin_q;
  logic [3:0]  min_q;
  logic [4:0]  din_q;
  logic [19:0] nin_q;
  logic [19:0] r_q;
  logic [11:0] yr_q;
  logic [2:0]  cnt_q;
  logic [1:0]  cc_q;
  logic [4:0]  bb_q;
  logic [1:0]  yi_q;
  logic [3:0]  mm_q;
  logic [2:0]  wd_q;
  logic        ok_q;

  logic        leap;
  logic [4:0]  mlen;
  logic [4:0]  mlen_in;
  logic [19:0] dd20;
  logic [11:0] yr12;
  logic        load_ok;
  logic        stage_take;
  logic        month_take;

  always_comb begin
    leap       = (yi_q == LEAP_POS) && ((bb_q != FINAL_BLOCK) || (cc_q == FINAL_CENT));
    mlen       = month_len(leap, mm_q);
    mlen_in    = month_len(leap, min_q);
    dd20       = {2'd0, cw_i.dd_step};
    yr12       = {3'd0, cw_i.yr_step};
    load_ok    = cmd_q ? (nin_q <= LAST_DAY)
                       : ((yin_q >= EPOCH_YEAR) && (min_q >= 4'd1) && (min_q <= MONTHS)
                          && (din_q != 5'd0));
    stage_take = (cnt_q < cw_i.cap) && (cmd_q ? (r_q >= dd20) : (yr_q >= yr12));
    month_take = cmd_q ? ((r_q >= {15'd0, mlen}) && (mm_q < MONTHS)) : (mm_q < min_q);
    sts_o      = '0;
    case (cw_i.op)
      OP_LOAD:   sts_o.fail = !load_ok;
      OP_MSETUP: sts_o.fail = !cmd_q && (din_q > mlen_in);
      OP_STAGE:  sts_o.again = stage_take;
      OP_MONTH:  sts_o.again = month_take;
      default:   sts_o = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_load_i) begin
      cmd_q <= in_data_i.command;
      yin_q <= in_data_i.year;
      min_q <= in_data_i.month;
      din_q <= in_data_i.day;
      nin_q <= in_data_i.day_number;
    end
    if (run_i) begin
      case (cw_i.op)
        OP_LOAD: begin
          ok_q  <= load_ok;
          cnt_q <= '0;
          cc_q  <= '0;
          bb_q  <= '0;
          yi_q  <= '0;
          mm_q  <= 4'd1;
          if (cmd_q) begin
            r_q  <= nin_q + EPOCH_OFS;
            yr_q <= '0;
            wd_q <= WD_BASE;
          end else begin
            r_q  <= {15'd0, din_q - 5'd1};
            yr_q <= yin_q - BASE_YEAR;
            wd_q <= add7(WD_BASE, mod7(din_q - 5'd1));
          end
        end
        OP_STAGE: begin
          if (stage_take) begin
            cnt_q <= cnt_q + 3'd1;
            wd_q  <= add7(wd_q, cw_i.wd_step);
            if (cmd_q) begin
              r_q  <= r_q - dd20;
              yr_q <= yr_q + yr12;
            end else begin
              r_q  <= r_q + dd20;
              yr_q <= yr_q - yr12;
            end
            case (cw_i.tally)
              TL_CENT: cc_q <= cc_q + 2'd1;
              TL_B8:   bb_q <= bb_q + 5'd8;
              TL_B1:   bb_q <= bb_q + 5'd1;
              TL_YEAR: yi_q <= yi_q + 2'd1;
              default: ;
            endcase
          end else begin
            cnt_q <= '0;
          end
        end
        OP_MSETUP: begin
          if (!cmd_q) begin
            r_q <= r_q - EPOCH_OFS;
            if (din_q > mlen_in) begin
              ok_q <= 1'b0;
            end
          end
        end
        OP_MONTH: begin
          if (month_take) begin
            mm_q <= mm_q + 4'd1;
            wd_q <= add7(wd_q, mod7(mlen));
            r_q  <= cmd_q ? (r_q - {15'd0, mlen}) : (r_q + {15'd0, mlen});
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res_o = '0;
    if (ok_q) begin
      res_o.valid_res = 1'b1;
      if (cmd_q) begin
        res_o.out_day_number = nin_q;
        res_o.out_year       = BASE_YEAR + yr_q;
        res_o.out_month      = mm_q;
        res_o.out_day        = r_q[4:0] + 5'd1;
        res_o.weekday        = add7(wd_q, mod7(r_q[4:0]));
      end else begin
        res_o.out_day_number = r_q;
        res_o.out_year       = yin_q;
        res_o.out_month      = min_q;
        res_o.out_day        = din_q;
        res_o.weekday        = wd_q;
      end
    end
  end

endmodule

@@ rtl/date_day_number_converter_unit.sv @@
// Top level of the date / day number converter: input capture, output
// register and handshakes. Depends on ddnc_pkg, ddnc_seq and ddnc_dp.
//
// Usage: present an item on in_data_i with in_valid_i; it transfers when
// in_stall_o is low. Command 0 turns a date into a day number counted from
// 1901-01-01, command 1 turns a day number into a date; both give the
// weekday (0 Sunday). One result leaves per item on out_data_o, qualified
// by out_valid_o, and transfers when out_stall_i is low.
// The time from an item's transfer to its result is set by the microcode
// loop that peels off 400, 100, 32, 4 and 1 years and then walks the
// months, one subtract per cycle; a rejected item leaves the loop early.
// One item is worked on at a time; in_stall_o is high while the sequencer
// runs and drops the cycle after the result is written, so the next item
// transfers while a result still waits.
// Stall: a held result stays in the output register; a finished item waits
// in its last step until the register is free.
// Reset: the sequencer returns to idle and the output register empties.
module date_day_number_converter_unit import ddnc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic      busy;
  logic      emit;
  logic      accept;
  logic      out_free;
  cw_t       cw;
  sts_t      sts;
  out_item_t res;
  logic      out_valid_q, out_valid_d;
  out_item_t out_data_q;

  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;
  assign out_free   = !out_valid_q || !out_stall_i;

  ddnc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .sts_i      (sts),
    .out_free_i (out_free),
    .busy_o     (busy),
    .emit_o     (emit),
    .cw_o       (cw)
  );

  ddnc_dp u_dp (
    .clk_i     (clk_i),
    .in_load_i (accept),
    .in_data_i (in_data_i),
    .run_i     (busy),
    .cw_i      (cw),
    .sts_o     (sts),
    .res_o     (res)
  );

  assign out_valid_d = emit || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("sequencer did not start on input transfer");

  a_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> !in_stall_o)
    else $error("sequencer still busy after result write");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.valid_res |->
      out_data_o.out_day_number == '0 && out_data_o.out_year == '0 &&
      out_data_o.out_month == '0 && out_data_o.out_day == '0 &&
      out_data_o.weekday == '0)
    else $error("rejected item has nonzero result fields");

  a_valid_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.valid_res |->
      out_data_o.out_month >= 4'd1 && out_data_o.out_month <= MONTHS &&
      out_data_o.out_day != 5'd0 && out_data_o.weekday <= 3'd6 &&
      out_data_o.out_day_number <= LAST_DAY)
    else $error("accepted result out of calendar range");
`endif

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for date_day_number_converter_unit: directed rows,
// then random dates and day numbers, checked against a calendar predictor.
// Depends on ddnc_pkg and the converter RTL.
`timescale 1ns / 100ps

module tb;
  import ddnc_pkg::*;

  localparam int LAST_YEAR   = 4095;
  localparam int RANDOM_REQS = 650;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN       = 64;
  localparam int ROWS        = 25;

  typedef struct {
    bit cmd;
    int year;
    int month;
    int day;
    int dnum;
    bit typed;
    int v;
    int on;
    int oy;
    int om;
    int od;
    int wd;
  } conv_row_t;

  // cmd year mon day dnum | typed valid dnum year mon day wday
  conv_row_t directed_rows [ROWS] = '{
    '{0, 1901,  1,  1, 0,        1, 1, 0,      1901,  1,  1, 2},
    '{1, 0,     0,  0, 0,        1, 1, 0,      1901,  1,  1, 2},
    '{0, 4095, 12, 31, 0,        1, 1, 801707, 4095, 12, 31, 6},
    '{1, 4095, 15, 31, 801707,   1, 1, 801707, 4095, 12, 31, 6},
    '{1, 0,     0,  0, 801708,   1, 0, 0, 0, 0, 0, 0},
    '{1, 4095, 15, 31, 'hFFFFF,  1, 0, 0, 0, 0, 0, 0},
    '{0, 1900, 12, 31, 0,        1, 0, 0, 0, 0, 0, 0},
    '{0, 0,     1,  1, 0,        1, 0, 0, 0, 0, 0, 0},
    '{0, 2000,  0,  1, 0,        1, 0, 0, 0, 0, 0, 0},
    '{0, 2000, 13,  1, 0,        1, 0, 0, 0, 0, 0, 0},
    '{0, 2000, 15, 31, 'hFFFFF,  1, 0, 0, 0, 0, 0, 0},
    '{0, 2000,  1,  0, 0,        1, 0, 0, 0, 0, 0, 0},
    '{0, 2001,  4, 31, 0,        1, 0, 0, 0, 0, 0, 0},
    '{0, 2100,  2, 29, 0,        1, 0, 0, 0, 0, 0, 0},
    '{0, 2001,  2, 29, 0,        1, 0, 0, 0, 0, 0, 0},
    '{0, 2000,  2, 29, 0,        0, 0, 0, 0, 0, 0, 0},
    '{0, 2004,  2, 29, 'hFFFFF,  0, 0, 0, 0, 0, 0, 0},
    '{0, 1999, 12, 31, 0,        0, 0, 0, 0, 0, 0, 0},
    '{1, 0,     0,  0, 36524,    0, 0, 0, 0, 0, 0, 0},
    '{1, 4095, 15, 31, 36159,    0, 0, 0, 0, 0, 0, 0},
    '{0, 4000,  2, 29, 0,        0, 0, 0, 0, 0, 0, 0},
    '{1, 0,     0,  0, 801343,   0, 0, 0, 0, 0, 0, 0},
    '{0, 3000, 12, 31, 0,        0, 0, 0, 0, 0, 0, 0},
    '{0, 1901, 12, 31, 0,        0, 0, 0, 0, 0, 0, 0},
    '{1, 0,     0,  0, 364,      0, 0, 0, 0, 0, 0, 0}
  };

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_data_o;

  out_item_t pending_results [$];
  int        mismatches    = 0;
  int        results_seen  = 0;
  int        dates_sent    = 0;
  int        numbers_sent  = 0;
  int        rejects_sent  = 0;
  int        quiet_cycles  = 0;
  bit        directed_done = 1'b0;
  bit        hold_done     = 1'b0;

  date_day_number_converter_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic bit leap_year(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int month_days(int y, int m);
    case (m)
      2:              return leap_year(y) ? 29 : 28;
      4, 6, 9, 11:    return 30;
      default:        return 31;
    endcase
  endfunction

  function automatic int days_to_year(int y);
    int p;
    p = y - 1;
    return 365 * p + p / 4 - p / 100 + p / 400;
  endfunction

  function automatic out_item_t predict_conversion(in_item_t req);
    out_item_t res;
    int base, last_n, n, y, m, d, rem;
    res    = '0;
    base   = days_to_year(int'(EPOCH_YEAR));
    last_n = days_to_year(LAST_YEAR + 1) - base - 1;
    y = int'(req.year);
    m = int'(req.month);
    d = int'(req.day);
    n = -1;
    if (req.command == 1'b0) begin
      if (y >= int'(EPOCH_YEAR) && y <= LAST_YEAR && m >= 1 && m <= 12 &&
          d >= 1 && d <= month_days(y, m)) begin
        n = days_to_year(y) - base + d - 1;
        for (int k = 1; k < m; k++) n += month_days(y, k);
      end
    end else if (int'(req.day_number) <= last_n) begin
      n   = int'(req.day_number);
      rem = n;
      y   = int'(EPOCH_YEAR);
      while (rem >= (leap_year(y) ? 366 : 365)) begin
        rem -= leap_year(y) ? 366 : 365;
        y++;
      end
      m = 1;
      while (m < 12 && rem >= month_days(y, m)) begin
        rem -= month_days(y, m);
        m++;
      end
      d = rem + 1;
    end
    if (n >= 0) begin
      res.valid_res      = 1'b1;
      res.out_day_number = 20'(n);
      res.out_year       = 12'(y);
      res.out_month      = 4'(m);
      res.out_day        = 5'(d);
      res.weekday        = 3'((n + (base + 1) % 7) % 7);
    end
    return res;
  endfunction

  function automatic in_item_t random_request();
    in_item_t req;
    int r, len;
    req            = '0;
    req.command    = 1'($urandom_range(0, 1));
    req.day_number = 20'($urandom);
    r = $urandom_range(0, 99);
    if (r < 70)      req.year = 12'($urandom_range(int'(EPOCH_YEAR), LAST_YEAR));
    else if (r < 80) req.year = 12'($urandom_range(int'(EPOCH_YEAR), 1910));
    else if (r < 90) req.year = 12'($urandom_range(20, 40) * 100);
    else             req.year = 12'($urandom);
    req.month = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(1, 12));
    len = month_days(int'(req.year), int'(req.month));
    r = $urandom_range(0, 99);
    if (r < 75)      req.day = 5'($urandom_range(1, len));
    else if (r < 88) req.day = 5'(len);
    else             req.day = 5'($urandom);
    r = $urandom_range(0, 99);
    if (r < 80)      req.day_number = 20'($urandom_range(0, int'(LAST_DAY)));
    else if (r < 90) req.day_number = 20'($urandom_range(int'(LAST_DAY) - 400,
                                                         int'(LAST_DAY) + 3));
    return req;
  endfunction

  function automatic int pick_gap(int idx);
    int r;
    if ((idx / 64) % 4 == 3) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_request(in_item_t req, out_item_t res, int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(res);
    if (!res.valid_res)        rejects_sent++;
    else if (req.command == 0) dates_sent++;
    else                       numbers_sent++;
  endtask

  initial begin
    in_item_t  req;
    out_item_t res;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_rows[i]) begin
      req.command    = directed_rows[i].cmd;
      req.year       = 12'(directed_rows[i].year);
      req.month      = 4'(directed_rows[i].month);
      req.day        = 5'(directed_rows[i].day);
      req.day_number = 20'(directed_rows[i].dnum);
      if (directed_rows[i].typed) begin
        res.valid_res      = 1'(directed_rows[i].v);
        res.out_day_number = 20'(directed_rows[i].on);
        res.out_year       = 12'(directed_rows[i].oy);
        res.out_month      = 4'(directed_rows[i].om);
        res.out_day        = 5'(directed_rows[i].od);
        res.weekday        = 3'(directed_rows[i].wd);
      end else begin
        res = predict_conversion(req);
      end
      send_request(req, res, pick_gap(i));
    end
    directed_done = 1'b1;
    for (int i = 0; i < RANDOM_REQS; i++) begin
      req = random_request();
      send_request(req, predict_conversion(req), pick_gap(i));
    end
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    $display("Checked %0d results: %0d dates, %0d day numbers, %0d rejected requests",
             results_seen, dates_sent, numbers_sent, rejects_sent);
    $display("Leap/century edges, range limits and a long output hold-off included");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hold off once for a long stretch, otherwise stall at random
  initial begin
    out_stall_i <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      int r;
      r = $urandom_range(0, 99);
      if (directed_done && !hold_done && results_seen > 0) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else if (r < 60) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end else if (r < 92) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(10, 60)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    out_item_t exp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected transfer: %p", out_data_o);
        mismatches++;
      end else begin
        exp = pending_results.pop_front();
        if (out_data_o !== exp) begin
          mismatches++;
          if (out_data_o.valid_res !== exp.valid_res)
            $error("valid_res: expected %0d, got %0d", exp.valid_res, out_data_o.valid_res);
          if (out_data_o.out_day_number !== exp.out_day_number)
            $error("out_day_number: expected %0d, got %0d",
                   exp.out_day_number, out_data_o.out_day_number);
          if (out_data_o.out_year !== exp.out_year)
            $error("out_year: expected %0d, got %0d", exp.out_year, out_data_o.out_year);
          if (out_data_o.out_month !== exp.out_month)
            $error("out_month: expected %0d, got %0d", exp.out_month, out_data_o.out_month);
          if (out_data_o.out_day !== exp.out_day)
            $error("out_day: expected %0d, got %0d", exp.out_day, out_data_o.out_day);
          if (out_data_o.weekday !== exp.weekday)
            $error("weekday: expected %0d, got %0d", exp.weekday, out_data_o.weekday);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

endmodule
